### rtl/mts_pkg.sv
// ----------------------------------------------------------------------------
// mts_pkg
// Shared constants and types for the min tracking stack.
// ----------------------------------------------------------------------------
`default_nettype none

package mts_pkg;

  localparam int unsigned ValueW = 16;
  localparam int unsigned EntryW = 18;
  localparam int unsigned OpW    = 2;
  localparam int unsigned StatW  = 2;

  localparam logic [OpW-1:0] OP_PUSH = 2'd0;
  localparam logic [OpW-1:0] OP_POP  = 2'd1;
  localparam logic [OpW-1:0] OP_MIN  = 2'd2;

  localparam logic [StatW-1:0] ST_OK    = 2'd0;
  localparam logic [StatW-1:0] ST_EMPTY = 2'd1;
  localparam logic [StatW-1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic [ValueW-1:0] value;
    logic [StatW-1:0]  status;
  } result_t;

endpackage

`default_nettype wire

### rtl/mts_store.sv
// ----------------------------------------------------------------------------
// mts_store
// Entry memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module mts_store #(
  parameter int unsigned Depth = 64,
  parameter int unsigned AddrW = 6
) (
  input  wire logic                             clk_i,
  input  wire logic                             wr_en_i,
  input  wire logic [AddrW-1:0]                 wr_addr_i,
  input  wire logic signed [mts_pkg::EntryW-1:0] wr_data_i,
  input  wire logic                             rd_en_i,
  input  wire logic [AddrW-1:0]                 rd_addr_i,
  output logic signed [mts_pkg::EntryW-1:0]     rd_data_o
);

  logic signed [mts_pkg::EntryW-1:0] mem [Depth];
  logic signed [mts_pkg::EntryW-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

### rtl/min_tracking_stack_top.sv
// ----------------------------------------------------------------------------
// min_tracking_stack_top
// LIFO stack of 16-bit values that reports its running minimum.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: in_valid_i / in_stall_o with opcode_i and push_value_i.
//   Opcodes: push, pop, read minimum; opcode three is a no-op.
//   Output channel: out_valid_o / out_stall_i with result_value_o, status_o.
//   Every input transaction yields exactly one output transaction.
//   Push, read minimum and no-op: result registered at the accepting edge,
//   one transaction per cycle unless a result waits under out_stall_i.
//   Pop: the top entry is read from the synchronous entry memory, which
//   registers its read data, and decoded in the next cycle.
//   A pop holds off the next transaction until its result is registered.
//   Values below the minimum are stored encoded as 2*value-min; the
//   minimum register restores on pop.
//   Reset empties the stack and drops any pending output transaction; the
//   memory is not cleared, its entries are only read below the fill count.
//   While a result waits under out_stall_i, in_stall_o stays high.
// ----------------------------------------------------------------------------
`default_nettype none

module min_tracking_stack_top #(
  parameter int unsigned STACK_DEPTH = 64
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_stall_o,
  input  wire logic [mts_pkg::OpW-1:0]     opcode_i,
  input  wire logic [mts_pkg::ValueW-1:0]  push_value_i,
  output logic                             out_valid_o,
  input  wire logic                        out_stall_i,
  output logic [mts_pkg::ValueW-1:0]       result_value_o,
  output logic [mts_pkg::StatW-1:0]        status_o
);

  localparam int unsigned AddrW  = $clog2(STACK_DEPTH);
  localparam int unsigned CountW = $clog2(STACK_DEPTH + 1);
  localparam int unsigned VW     = mts_pkg::ValueW;
  localparam int unsigned EW     = mts_pkg::EntryW;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_READ = 1'b1;

  logic                 state_q, state_d;
  logic [CountW-1:0]    count_q, count_d;
  logic [VW-1:0]        min_q, min_d;
  logic                 out_valid_q, out_valid_d;
  mts_pkg::result_t     res_q, res_d;

  logic                 out_free;
  logic                 accept;
  logic                 empty;
  logic                 full;
  logic                 wr_en;
  logic                 rd_en;
  logic [AddrW-1:0]     wr_addr;
  logic [AddrW-1:0]     rd_addr;
  logic signed [EW-1:0] wr_data;
  logic signed [EW-1:0] rd_data;
  logic signed [EW-1:0] min_ext;
  logic signed [EW-1:0] enc_val;
  logic [EW-1:0]        restore;

  assign out_free = !out_valid_q || !out_stall_i;
  assign accept   = in_valid_i && !in_stall_o;
  assign empty    = (count_q == '0);
  assign full     = (count_q == CountW'(STACK_DEPTH));

  assign in_stall_o = (state_q != S_IDLE) || !out_free;

  assign min_ext = $signed({2'b00, min_q});
  assign enc_val = $signed({1'b0, push_value_i, 1'b0}) - min_ext;
  assign restore = {1'b0, min_q, 1'b0} - rd_data;

  assign wr_addr = count_q[AddrW-1:0];
  assign rd_addr = AddrW'(count_q - CountW'(1));
  assign rd_en   = accept && (opcode_i == mts_pkg::OP_POP) && !empty;

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    min_d       = min_q;
    out_valid_d = out_valid_q && out_stall_i;
    res_d       = res_q;
    wr_en       = 1'b0;
    wr_data     = $signed({2'b00, push_value_i});

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          res_d.value  = '0;
          res_d.status = mts_pkg::ST_OK;
          out_valid_d  = 1'b1;
          unique case (opcode_i)
            mts_pkg::OP_PUSH: begin
              if (full) begin
                res_d.status = mts_pkg::ST_FULL;
              end else begin
                wr_en   = 1'b1;
                count_d = count_q + CountW'(1);
                if (empty) begin
                  min_d = push_value_i;
                end else if (push_value_i < min_q) begin
                  wr_data = enc_val;
                  min_d   = push_value_i;
                end
              end
            end
            mts_pkg::OP_POP: begin
              if (empty) begin
                res_d.status = mts_pkg::ST_EMPTY;
              end else begin
                out_valid_d = 1'b0;
                count_d     = count_q - CountW'(1);
                state_d     = S_READ;
              end
            end
            mts_pkg::OP_MIN: begin
              if (empty) begin
                res_d.status = mts_pkg::ST_EMPTY;
              end else begin
                res_d.value = min_q;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_READ: begin
        out_valid_d  = 1'b1;
        res_d.status = mts_pkg::ST_OK;
        if (rd_data < min_ext) begin
          res_d.value = min_q;
          min_d       = restore[VW-1:0];
        end else begin
          res_d.value = rd_data[VW-1:0];
        end
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      min_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      min_q       <= min_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  mts_store #(
    .Depth (STACK_DEPTH),
    .AddrW (AddrW)
  ) u_store (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  assign out_valid_o    = out_valid_q;
  assign result_value_o = res_q.value;
  assign status_o       = res_q.status;

endmodule

`default_nettype wire

### rtl/mts_checker.sv
// ----------------------------------------------------------------------------
// mts_checker
// Port-level checks on the min tracking stack, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module mts_checker (
  input wire logic                       clk_i,
  input wire logic                       rst_ni,
  input wire logic                       in_valid_i,
  input wire logic                       in_stall_o,
  input wire logic [mts_pkg::OpW-1:0]    opcode_i,
  input wire logic                       out_valid_o,
  input wire logic                       out_stall_i,
  input wire logic [mts_pkg::ValueW-1:0] result_value_o,
  input wire logic [mts_pkg::StatW-1:0]  status_o
);

  logic in_acc;

  assign in_acc = in_valid_i && !in_stall_o;

  a_status_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (status_o == mts_pkg::ST_OK || status_o == mts_pkg::ST_EMPTY ||
                     status_o == mts_pkg::ST_FULL))
    else $error("status code out of range");

  a_error_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o != mts_pkg::ST_OK) |-> (result_value_o == '0))
    else $error("error result carries a nonzero value");

  a_short_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && opcode_i != mts_pkg::OP_POP) |=> out_valid_o)
    else $error("missing result one cycle after transaction");

  a_pop_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && opcode_i == mts_pkg::OP_POP) |=> (in_stall_o || out_valid_o))
    else $error("pop neither produced a result nor held off input");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=>
      (out_valid_o && $stable(result_value_o) && $stable(status_o)))
    else $error("stalled output transaction changed");

endmodule

bind min_tracking_stack_top mts_checker u_mts_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_stall_o     (in_stall_o),
  .opcode_i       (opcode_i),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .result_value_o (result_value_o),
  .status_o       (status_o)
);

`default_nettype wire

### bench/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Directed and random check of the min tracking stack. A queue of stack
// operations feeds a bursty driver; a running stack model predicts every
// result, and a monitor under a changing stall pattern checks each one.
// ----------------------------------------------------------------------------

module tb_top;

  localparam int unsigned StackDepth  = 64;
  localparam int unsigned RandomItems = 1850;
  localparam int unsigned CycleLimit  = 400000;

  localparam logic [mts_pkg::OpW-1:0] OP_NOP = 2'd3;

  typedef enum int {SEG_FILL, SEG_DRAIN, SEG_MIX} seg_mode_e;
  typedef enum int {VAL_ANY, VAL_FALLING, VAL_CORNER, VAL_CLUSTER} val_mode_e;
  typedef enum int {STALL_NONE, STALL_SPARSE, STALL_PERIODIC, STALL_HEAVY} stall_mode_e;

  typedef struct {
    logic [mts_pkg::OpW-1:0]    opcode;
    logic [mts_pkg::ValueW-1:0] value;
    bit                         hold_idle;
  } stack_op_t;

  logic                       clk   = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       in_valid  = 1'b0;
  logic [mts_pkg::OpW-1:0]    in_opcode = OP_NOP;
  logic [mts_pkg::ValueW-1:0] in_value  = '0;
  logic                       out_stall = 1'b0;
  logic                       in_stall;
  logic                       out_valid;
  logic [mts_pkg::ValueW-1:0] result_value;
  logic [mts_pkg::StatW-1:0]  status;

  stack_op_t        op_queue[$];
  mts_pkg::result_t stack_results[$];
  stack_op_t        cur_op;
  int unsigned      mismatch_count = 0;
  int unsigned      accepted_count = 0;
  int unsigned      checked_count  = 0;
  int unsigned      cycle_count    = 0;
  int unsigned      burst_left     = 1;
  int unsigned      gap_left       = 0;
  int unsigned      stall_left     = 0;
  stall_mode_e      stall_mode     = STALL_NONE;

  // stack model state
  logic signed [mts_pkg::EntryW-1:0] entry_mem [StackDepth];
  int unsigned                       held_count = 0;
  logic [mts_pkg::ValueW-1:0]        run_min    = '0;

  min_tracking_stack_top #(
    .STACK_DEPTH(StackDepth)
  ) dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .opcode_i      (in_opcode),
    .push_value_i  (in_value),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .result_value_o(result_value),
    .status_o      (status)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic mts_pkg::result_t apply_stack_op(
      input logic [mts_pkg::OpW-1:0] opcode,
      input logic [mts_pkg::ValueW-1:0] value);
    mts_pkg::result_t                  r;
    int                                t;
    logic signed [mts_pkg::EntryW-1:0] top;
    r.value  = '0;
    r.status = mts_pkg::ST_OK;
    case (opcode)
      mts_pkg::OP_PUSH: begin
        if (held_count >= StackDepth) begin
          r.status = mts_pkg::ST_FULL;
        end else begin
          if (held_count != 0 && value < run_min) begin
            t = 2 * int'(value) - int'(run_min);
            entry_mem[held_count] = t[mts_pkg::EntryW-1:0];
            run_min = value;
          end else begin
            if (held_count == 0) run_min = value;
            entry_mem[held_count] = {2'b00, value};
          end
          held_count++;
        end
      end
      mts_pkg::OP_POP: begin
        if (held_count == 0) begin
          r.status = mts_pkg::ST_EMPTY;
        end else begin
          top = entry_mem[held_count - 1];
          held_count--;
          if (int'(top) < int'(run_min)) begin
            r.value = run_min;
            t = 2 * int'(run_min) - int'(top);
            run_min = t[mts_pkg::ValueW-1:0];
          end else begin
            r.value = top[mts_pkg::ValueW-1:0];
          end
        end
      end
      mts_pkg::OP_MIN: begin
        if (held_count == 0) r.status = mts_pkg::ST_EMPTY;
        else r.value = run_min;
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    mismatch_count++;
    $display("mismatch at result %0d: %s got %0h expected %0h",
             checked_count, what, got, want);
  endtask

  task automatic add_op(input logic [mts_pkg::OpW-1:0] opcode,
                        input logic [mts_pkg::ValueW-1:0] value,
                        input bit hold_idle);
    stack_op_t item;
    item.opcode    = opcode;
    item.value     = value;
    item.hold_idle = hold_idle;
    op_queue.push_back(item);
  endtask

  // driver: bursts of transactions with random gaps
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        stack_results.push_back(apply_stack_op(cur_op.opcode, cur_op.value));
        accepted_count++;
      end
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (op_queue.size() > 0 &&
                     !(op_queue[0].hold_idle && stack_results.size() != 0)) begin
          cur_op = op_queue.pop_front();
          in_valid  <= 1'b1;
          in_opcode <= cur_op.opcode;
          in_value  <= cur_op.value;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 48);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end else begin
            burst_left--;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: check each result transaction, stall on a shifting pattern
  always @(posedge clk) begin
    mts_pkg::result_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (stack_results.size() == 0) begin
          report_mismatch("unexpected result", int'(result_value), 0);
        end else begin
          want = stack_results.pop_front();
          if (result_value !== want.value)
            report_mismatch("result_value", int'(result_value), int'(want.value));
          if (status !== want.status)
            report_mismatch("status", int'(status), int'(want.status));
        end
        checked_count++;
      end
      if (stall_left == 0) begin
        stall_mode = stall_mode_e'($urandom_range(0, 3));
        stall_left = $urandom_range(16, 256);
      end else begin
        stall_left--;
      end
      case (stall_mode)
        STALL_NONE:     out_stall <= 1'b0;
        STALL_SPARSE:   out_stall <= ($urandom_range(0, 3) == 0);
        STALL_PERIODIC: out_stall <= (cycle_count % 3 == 1);
        default:        out_stall <= ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    seg_mode_e                  seg_mode;
    val_mode_e                  val_mode;
    int unsigned                seg_left;
    int unsigned                pick;
    logic [mts_pkg::OpW-1:0]    op;
    logic [mts_pkg::ValueW-1:0] val;
    logic [mts_pkg::ValueW-1:0] last_val;
    logic [mts_pkg::ValueW-1:0] base;
    seg_mode = SEG_FILL;
    val_mode = VAL_ANY;
    seg_left = 0;
    last_val = '1;
    base     = '0;

    // empty stack, unused opcode, extremes, encoded restores
    add_op(mts_pkg::OP_POP,  16'h0000, 1'b0);
    add_op(mts_pkg::OP_MIN,  16'hFFFF, 1'b0);
    add_op(OP_NOP,           16'hFFFF, 1'b0);
    add_op(mts_pkg::OP_PUSH, 16'hFFFF, 1'b0);
    add_op(mts_pkg::OP_PUSH, 16'hFFFF, 1'b0);
    add_op(mts_pkg::OP_MIN,  16'h0000, 1'b0);
    add_op(mts_pkg::OP_PUSH, 16'h0000, 1'b0);
    add_op(mts_pkg::OP_MIN,  16'h0000, 1'b0);
    add_op(mts_pkg::OP_PUSH, 16'h8000, 1'b0);
    add_op(mts_pkg::OP_POP,  16'h0000, 1'b0);
    add_op(mts_pkg::OP_POP,  16'h0000, 1'b0);
    add_op(mts_pkg::OP_MIN,  16'h0000, 1'b0);
    add_op(mts_pkg::OP_PUSH, 16'h7FFF, 1'b0);
    add_op(mts_pkg::OP_PUSH, 16'h5555, 1'b0);
    add_op(mts_pkg::OP_PUSH, 16'hAAAA, 1'b0);
    add_op(OP_NOP,           16'h1234, 1'b0);
    add_op(mts_pkg::OP_POP,  16'h0000, 1'b0);
    add_op(mts_pkg::OP_POP,  16'h0000, 1'b0);
    add_op(mts_pkg::OP_POP,  16'h0000, 1'b0);
    add_op(mts_pkg::OP_POP,  16'h0000, 1'b0);
    add_op(mts_pkg::OP_POP,  16'h0000, 1'b0);
    add_op(mts_pkg::OP_MIN,  16'h0000, 1'b0);
    add_op(mts_pkg::OP_PUSH, 16'h1234, 1'b0);
    add_op(mts_pkg::OP_POP,  16'h0000, 1'b0);

    // segments that fill, drain or mix, each with its own value style
    for (int n = 0; n < RandomItems; n++) begin
      if (seg_left == 0) begin
        seg_mode = (n == 0) ? SEG_FILL : seg_mode_e'($urandom_range(0, 2));
        val_mode = (n == 0) ? VAL_FALLING : val_mode_e'($urandom_range(0, 3));
        seg_left = (n == 0) ? 140 : $urandom_range(20, 120);
        base     = $urandom_range(0, 65535);
        last_val = $urandom_range(0, 65535);
      end
      seg_left--;
      pick = $urandom_range(0, 99);
      case (seg_mode)
        SEG_FILL:  op = (pick < 85) ? mts_pkg::OP_PUSH : (pick < 93) ? mts_pkg::OP_MIN :
                        (pick < 98) ? mts_pkg::OP_POP : OP_NOP;
        SEG_DRAIN: op = (pick < 80) ? mts_pkg::OP_POP : (pick < 90) ? mts_pkg::OP_MIN :
                        (pick < 96) ? mts_pkg::OP_PUSH : OP_NOP;
        default:   op = (pick < 45) ? mts_pkg::OP_PUSH : (pick < 75) ? mts_pkg::OP_POP :
                        (pick < 95) ? mts_pkg::OP_MIN : OP_NOP;
      endcase
      if (op == mts_pkg::OP_PUSH) begin
        case (val_mode)
          VAL_ANY:     val = $urandom_range(0, 65535);
          VAL_FALLING: begin
            last_val = last_val - $urandom_range(0, 900);
            val = last_val;
          end
          VAL_CORNER: begin
            case ($urandom_range(0, 5))
              0:       val = 16'h0000;
              1:       val = 16'h0001;
              2:       val = 16'h7FFF;
              3:       val = 16'h8000;
              4:       val = 16'hFFFE;
              default: val = 16'hFFFF;
            endcase
          end
          default:     val = base + $urandom_range(0, 15);
        endcase
      end else begin
        val = $urandom_range(0, 65535);
      end
      add_op(op, val, (n % 400 == 0));
    end

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    while (op_queue.size() != 0 || in_valid) @(posedge clk);
    while (stack_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

### files.f
rtl/mts_pkg.sv
rtl/mts_store.sv
rtl/min_tracking_stack_top.sv
rtl/mts_checker.sv
bench/tb_top.sv
